// ===== rtl/core/brhp_pkg.sv =====
// Shared types and constants for the byte range header parser.
// Fixed field widths, character codes, status codes and the result queue entry.
// No dependencies.
package brhp_pkg;

   localparam int SIZE_W   = 48;
   localparam int OFFSET_W = 48;
   localparam int LENGTH_W = 49;
   localparam int STATUS_W = 2;
   localparam int BYTE_W   = 8;

   // result queue: 8 entries, a new byte is taken while at most 2 are queued
   localparam int FIFO_DEPTH      = 8;
   localparam int FIFO_IDX_W      = 3;
   localparam int FIFO_CNT_W      = 4;
   localparam int FIFO_ACCEPT_MAX = FIFO_DEPTH - 6;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NONE      = 2'd2;

   localparam logic [BYTE_W-1:0] CHAR_DASH  = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;

   localparam logic [BYTE_W-1:0] CHAR_B  = 8'h62;
   localparam logic [BYTE_W-1:0] CHAR_Y  = 8'h79;
   localparam logic [BYTE_W-1:0] CHAR_T  = 8'h74;
   localparam logic [BYTE_W-1:0] CHAR_E  = 8'h65;
   localparam logic [BYTE_W-1:0] CHAR_S  = 8'h73;
   localparam logic [BYTE_W-1:0] CHAR_EQ = 8'h3D;

   typedef struct packed {
      logic                is_status;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] length;
      logic [STATUS_W-1:0] status;
   } rsp_entry_type;

   // expected character of the "bytes=" prefix at position idx
   function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         3'd0: ch = CHAR_B;
         3'd1: ch = CHAR_Y;
         3'd2: ch = CHAR_T;
         3'd3: ch = CHAR_E;
         3'd4: ch = CHAR_S;
         3'd5: ch = CHAR_EQ;
         default: ch = '0;
      endcase
      return ch;
   endfunction

   function automatic logic is_ws(input logic [BYTE_W-1:0] ch);
      return (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] ch);
      return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
   endfunction

endpackage

// ===== rtl/core/byte_range_header_parser_top.sv =====
// Byte range header parser, top level.
// Parse stage, range clamp stage and result queue in one module.
// Depends on brhp_pkg.

// Takes an HTTP Range header ("bytes=" followed by comma-separated ranges
// first-last, first- and -count) one byte per beat on the req_ channel, with
// req_end_of_header marking the last byte. For every satisfiable range one
// range beat leaves on rsp_ (offset and length clamped to csr_total_size);
// the last byte of a header always adds one status beat (rsp_is_status and
// rsp_last_result high) carrying ok, malformed or nothing satisfiable. On a
// malformed status the consumer drops the range beats it got for that header.
// Numbers saturate at 2**POSITION_WIDTH - 1. A range starting at or past the
// end of the resource is dropped silently and parsing goes on.
// Timing: one byte per cycle, back to back, while req_stall is low. A byte
// passes an input register, the parse stage (digit shift-add, phase update)
// and the clamp stage (compare and subtract against total size) and writes
// its results into an 8-entry queue, from which its first result shows on rsp_.
// A byte can produce two results (a range closed by the final byte plus the
// status), so req_stall rises whenever more than two results sit in the queue;
// with rsp_stall low the input side never stalls in practice. csr_total_size
// is sampled on csr_write_enable and should only change between headers when
// no beat is in flight. No clearing pass after reset.
module byte_range_header_parser_top #(
   parameter int POSITION_WIDTH = 48
) (
   input  logic                            clock,
   input  logic                            reset,
   // header byte channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [brhp_pkg::BYTE_W-1:0]     req_header_byte,
   input  logic                            req_end_of_header,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_is_status,
   output logic [brhp_pkg::OFFSET_W-1:0]   rsp_range_offset,
   output logic [brhp_pkg::LENGTH_W-1:0]   rsp_range_length,
   output logic [brhp_pkg::STATUS_W-1:0]   rsp_status,
   output logic                            rsp_last_result,
   // configuration
   input  logic                            csr_write_enable,
   input  logic [brhp_pkg::SIZE_W-1:0]     csr_total_size
);

   localparam int PW    = POSITION_WIDTH;
   // common width for comparing positions with the resource size
   localparam int CW    = (PW > brhp_pkg::SIZE_W) ? PW : brhp_pkg::SIZE_W;
   localparam int IDX_W = brhp_pkg::FIFO_IDX_W;
   localparam int CNT_W = brhp_pkg::FIFO_CNT_W;

   typedef enum logic [3:0] {
      PH_B, PH_Y, PH_T, PH_E, PH_S, PH_EQ,
      PH_START, PH_FIRST, PH_LAST, PH_SUFFIX, PH_AFTER, PH_START_SP
   } phase_type;

   // work handed from the parse stage to the clamp stage
   typedef struct packed {
      logic          close;   // close the range held in first/last
      logic          status;  // header ends: emit the status beat
      logic          bad;     // parse found the header malformed
      logic          suffix;
      logic          saw;     // part after the dash has digits
      logic [PW-1:0] first;
      logic [PW-1:0] last;
   } job_type;

   // saturating acc*10 + d
   function automatic logic [PW-1:0] push_digit(input logic [PW-1:0] acc,
                                                input logic [3:0]    d);
      logic [PW+3:0] prod;
      prod = ((PW+4)'(acc) << 3) + ((PW+4)'(acc) << 1) + (PW+4)'(d);
      if (prod[PW+3:PW] != '0) begin
         return '1;
      end
      return prod[PW-1:0];
   endfunction

   //----------------------------------------------------------------------
   // configuration
   //----------------------------------------------------------------------
   logic [brhp_pkg::SIZE_W-1:0] total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else if (csr_write_enable) begin
         total_ff <= csr_total_size;
      end
   end

   //----------------------------------------------------------------------
   // input register
   //----------------------------------------------------------------------
   logic                        in_vld_ff;
   logic                        in_vld_in;
   logic [brhp_pkg::BYTE_W-1:0] in_byte_ff;
   logic                        in_end_ff;
   logic [CNT_W-1:0]            count_ff;

   assign req_stall = (count_ff > CNT_W'(brhp_pkg::FIFO_ACCEPT_MAX));
   assign in_vld_in = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld_in) begin
         in_byte_ff <= req_header_byte;
         in_end_ff  <= req_end_of_header;
      end
   end

   //----------------------------------------------------------------------
   // parse stage
   //----------------------------------------------------------------------
   phase_type                   phase_ff, phase_in, ph_post;
   logic [PW-1:0]               first_ff, first_in, first_post;
   logic [PW-1:0]               last_ff, last_in, last_post;
   logic                        suffix_ff, suffix_in, suffix_post;
   logic                        saw_ff, saw_in, saw_post;
   logic                        bad_ff, bad_in, bad_post;
   logic [brhp_pkg::BYTE_W-1:0] c_off;
   logic [3:0]                  dig;
   logic [PW-1:0]               acc_pushed;
   logic                        c_ws, c_digit, c_dash, c_comma;
   logic                        byte_close;
   job_type                     job_in, job_ff;
   logic                        job_vld_ff;

   assign c_off      = in_byte_ff - brhp_pkg::CHAR_ZERO;
   assign dig        = c_off[3:0];
   assign c_ws       = brhp_pkg::is_ws(in_byte_ff);
   assign c_digit    = brhp_pkg::is_digit(in_byte_ff);
   assign c_dash     = (in_byte_ff == brhp_pkg::CHAR_DASH);
   assign c_comma    = (in_byte_ff == brhp_pkg::CHAR_COMMA);
   // one shift-add serves both numbers
   assign acc_pushed = push_digit((phase_ff == PH_FIRST) ? first_ff : last_ff, dig);

   always_comb begin
      ph_post     = phase_ff;
      first_post  = first_ff;
      last_post   = last_ff;
      suffix_post = suffix_ff;
      saw_post    = saw_ff;
      bad_post    = bad_ff;
      byte_close  = 1'b0;

      if (!bad_ff) begin
         case (phase_ff)
            PH_START, PH_START_SP: begin
               if (c_ws) begin
                  ph_post = PH_START_SP;
               end else if (c_dash) begin
                  ph_post     = PH_SUFFIX;
                  suffix_post = 1'b1;
                  first_post  = '0;
                  last_post   = '0;
                  saw_post    = 1'b0;
               end else if (c_digit) begin
                  ph_post     = PH_FIRST;
                  suffix_post = 1'b0;
                  first_post  = PW'(dig);
                  last_post   = '0;
                  saw_post    = 1'b0;
               end else begin
                  bad_post = 1'b1;
               end
            end
            PH_FIRST: begin
               if (c_digit) begin
                  first_post = acc_pushed;
               end else if (c_dash) begin
                  ph_post = PH_LAST;
               end else begin
                  bad_post = 1'b1;
               end
            end
            PH_LAST, PH_SUFFIX: begin
               if (c_digit) begin
                  last_post = acc_pushed;
                  saw_post  = 1'b1;
               end else if (c_comma || c_ws) begin
                  byte_close = 1'b1;
                  ph_post    = c_comma ? PH_START : PH_AFTER;
               end else begin
                  bad_post = 1'b1;
               end
            end
            PH_AFTER: begin
               if (c_comma) begin
                  ph_post = PH_START;
               end else if (!c_ws) begin
                  bad_post = 1'b1;
               end
            end
            default: begin
               // prefix letters
               if ((phase_ff <= PH_EQ) &&
                   (in_byte_ff == brhp_pkg::prefix_char(phase_ff[2:0]))) begin
                  ph_post = phase_type'(phase_ff + 4'd1);
               end else begin
                  bad_post = 1'b1;
               end
            end
         endcase
      end

      job_in.close  = byte_close;
      job_in.status = 1'b0;
      job_in.suffix = suffix_post;
      job_in.saw    = saw_post;
      job_in.first  = first_post;
      job_in.last   = last_post;

      if (in_end_ff && !bad_post) begin
         if ((ph_post == PH_LAST) || (ph_post == PH_SUFFIX)) begin
            job_in.close = 1'b1;
         end else if ((ph_post != PH_START) && (ph_post != PH_AFTER)) begin
            bad_post = 1'b1;
         end
      end
      job_in.bad = bad_post;

      phase_in  = ph_post;
      first_in  = first_post;
      last_in   = last_post;
      suffix_in = suffix_post;
      saw_in    = saw_post;
      bad_in    = bad_post;

      if (in_end_ff) begin
         // header done: back to the prefix for the next one
         job_in.status = 1'b1;
         phase_in      = PH_B;
         first_in      = '0;
         last_in       = '0;
         suffix_in     = 1'b0;
         saw_in        = 1'b0;
         bad_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_B;
         first_ff   <= '0;
         last_ff    <= '0;
         suffix_ff  <= 1'b0;
         saw_ff     <= 1'b0;
         bad_ff     <= 1'b0;
         job_vld_ff <= 1'b0;
      end else begin
         job_vld_ff <= in_vld_ff;
         if (in_vld_ff) begin
            phase_ff  <= phase_in;
            first_ff  <= first_in;
            last_ff   <= last_in;
            suffix_ff <= suffix_in;
            saw_ff    <= saw_in;
            bad_ff    <= bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_vld_ff) begin
         job_ff <= job_in;
      end
   end

   //----------------------------------------------------------------------
   // clamp stage: turns a closed range into offset/length, builds status
   //----------------------------------------------------------------------
   logic [CW-1:0]            size_c, f_c, l_c;
   logic [CW-1:0]            n_sfx, off_sfx, l_clamp, minuend;
   logic [CW:0]              len_span;
   logic                     f_lt_size, f_gt_l;
   logic                     rev_ff, rev_in, rev_now;
   logic                     any_ff, any_in;
   logic                     close_ok, close_emit;
   logic [brhp_pkg::STATUS_W-1:0] status_val;
   brhp_pkg::rsp_entry_type  range_entry, status_entry, wr_entry0;
   logic [1:0]               push_cnt;

   assign size_c    = CW'(total_ff);
   assign f_c       = CW'(job_ff.first);
   assign l_c       = CW'(job_ff.last);
   assign f_lt_size = (f_c < size_c);
   assign f_gt_l    = (f_c > l_c);

   assign n_sfx     = (l_c < size_c) ? l_c : size_c;
   assign off_sfx   = size_c - n_sfx;
   assign l_clamp   = (l_c >= size_c) ? (size_c - CW'(1)) : l_c;
   // first-last: last - first + 1, open end: size - first
   assign minuend   = job_ff.saw ? l_clamp : size_c;
   assign len_span  = (CW+1)'(minuend) - (CW+1)'(f_c) + (CW+1)'(job_ff.saw);

   always_comb begin
      if (job_ff.suffix) begin
         close_ok = (n_sfx != '0);
      end else if (job_ff.saw) begin
         close_ok = !f_gt_l && f_lt_size;
      end else begin
         close_ok = f_lt_size;
      end
   end

   // a reversed range makes the rest of the header malformed
   assign rev_now    = job_vld_ff && job_ff.close && !rev_ff &&
                       !job_ff.suffix && job_ff.saw && f_gt_l;
   assign close_emit = job_vld_ff && job_ff.close && !rev_ff && close_ok;

   always_comb begin
      if (job_ff.bad || rev_ff || rev_now) begin
         status_val = brhp_pkg::STATUS_MALFORMED;
      end else if (any_ff || close_emit) begin
         status_val = brhp_pkg::STATUS_OK;
      end else begin
         status_val = brhp_pkg::STATUS_NONE;
      end
   end

   always_comb begin
      range_entry.is_status = 1'b0;
      range_entry.status    = brhp_pkg::STATUS_OK;
      if (job_ff.suffix) begin
         range_entry.offset = off_sfx[brhp_pkg::OFFSET_W-1:0];
         range_entry.length = brhp_pkg::LENGTH_W'(n_sfx[brhp_pkg::OFFSET_W-1:0]);
      end else begin
         range_entry.offset = f_c[brhp_pkg::OFFSET_W-1:0];
         range_entry.length = len_span[brhp_pkg::LENGTH_W-1:0];
      end

      status_entry.is_status = 1'b1;
      status_entry.offset    = '0;
      status_entry.length    = '0;
      status_entry.status    = status_val;

      wr_entry0 = close_emit ? range_entry : status_entry;
      push_cnt  = 2'(close_emit) + 2'(job_vld_ff && job_ff.status);
   end

   always_comb begin
      if (job_vld_ff && job_ff.status) begin
         rev_in = 1'b0;
         any_in = 1'b0;
      end else begin
         rev_in = rev_ff | rev_now;
         any_in = any_ff | close_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff <= 1'b0;
         any_ff <= 1'b0;
      end else begin
         rev_ff <= rev_in;
         any_ff <= any_in;
      end
   end

   //----------------------------------------------------------------------
   // result queue
   //----------------------------------------------------------------------
   brhp_pkg::rsp_entry_type mem_ff [brhp_pkg::FIFO_DEPTH];
   brhp_pkg::rsp_entry_type head;
   logic [IDX_W-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_in;
   logic                    pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & ~rsp_stall;
   assign wr_ptr_in = wr_ptr_ff + IDX_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + IDX_W'(pop);
   assign count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= wr_entry0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_ff + IDX_W'(1)] <= status_entry;
      end
   end

   assign head             = mem_ff[rd_ptr_ff];
   assign rsp_is_status    = head.is_status;
   assign rsp_range_offset = head.offset;
   assign rsp_range_length = head.length;
   assign rsp_status       = head.status;
   assign rsp_last_result  = head.is_status;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for byte_range_header_parser_top.
// Feeds header bytes on req_, checks rsp_ beats against an in-bench parse model.
// Depends on brhp_pkg and the RTL top level; reads no files.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Saturation point of decimal numbers, at POSITION_WIDTH = 48
   localparam logic [63:0] POS_LIMIT    = (64'd1 << 48) - 64'd1;
   localparam logic [63:0] SIZE_MASK    = (64'd1 << brhp_pkg::SIZE_W) - 64'd1;
   localparam logic [47:0] PREFIX_TEXT  = {brhp_pkg::CHAR_B, brhp_pkg::CHAR_Y,
                                           brhp_pkg::CHAR_T, brhp_pkg::CHAR_E,
                                           brhp_pkg::CHAR_S, brhp_pkg::CHAR_EQ};
   localparam int          SETTLE_CYCLES = 8;        // input reg + parse + clamp + queue
   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          RANDOM_BYTES  = 700;
   localparam int          BYTES_PER_SIZE = 300;     // random bytes between size changes

   typedef logic [brhp_pkg::BYTE_W-1:0] hbyte_type;

   // parse position: six prefix letters, then the range grammar
   typedef enum logic [3:0] {
      ST_B, ST_Y, ST_T, ST_E, ST_S, ST_EQ,
      ST_RANGE, ST_FIRST, ST_LAST, ST_SUFFIX, ST_TRAIL, ST_RANGE_WS
   } parse_state_type;

   typedef struct packed {
      logic                          is_status;
      logic [brhp_pkg::OFFSET_W-1:0] offset;
      logic [brhp_pkg::LENGTH_W-1:0] length;
      logic [brhp_pkg::STATUS_W-1:0] status;
      logic                          last;
   } range_beat_type;

   // ---------------------------------------------------------------- DUT I/O
   logic                          clock;
   logic                          reset             = 1'b1;
   logic                          req_valid         = 1'b0;
   logic                          req_stall;
   hbyte_type                     req_header_byte   = '0;
   logic                          req_end_of_header = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall         = 1'b0;
   logic                          rsp_is_status;
   logic [brhp_pkg::OFFSET_W-1:0] rsp_range_offset;
   logic [brhp_pkg::LENGTH_W-1:0] rsp_range_length;
   logic [brhp_pkg::STATUS_W-1:0] rsp_status;
   logic                          rsp_last_result;
   logic                          csr_write_enable  = 1'b0;
   logic [brhp_pkg::SIZE_W-1:0]   csr_total_size    = '0;

   byte_range_header_parser_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_header_byte   (req_header_byte),
      .req_end_of_header (req_end_of_header),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_status     (rsp_is_status),
      .rsp_range_offset  (rsp_range_offset),
      .rsp_range_length  (rsp_range_length),
      .rsp_status        (rsp_status),
      .rsp_last_result   (rsp_last_result),
      .csr_write_enable  (csr_write_enable),
      .csr_total_size    (csr_total_size)
   );

   // ------------------------------------------------------- bench-wide state
   range_beat_type expected_rsp_beats[$];  // beats owed by the DUT, oldest first
   hbyte_type      header_text[$];         // header being assembled for sending
   int unsigned    fail_count        = 0;
   int unsigned    cycle_count       = 0;
   int unsigned    header_bytes_sent = 0;
   bit             send_burst        = 1'b0;  // sender: no gaps while set
   bit             rsp_burst         = 1'b0;  // receiver: no stalls while set
   int             rsp_hold_cycles   = 0;     // one-shot long receiver hold-off

   // Parse model state; mirrors what the block must hold per header
   logic [brhp_pkg::SIZE_W-1:0] model_total_size = '0;
   parse_state_type   hdr_state        = ST_B;
   logic [47:0]       cur_first        = '0;
   logic [47:0]       cur_last         = '0;
   bit                cur_is_suffix    = 1'b0;
   bit                cur_have_last    = 1'b0;
   bit                hdr_any_range    = 1'b0;
   bit                hdr_malformed    = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------ queue helpers
   task automatic add_text_byte(input hbyte_type c);
      header_text.insert(header_text.size(), c);
   endtask

   task automatic owe_beat(input range_beat_type beat);
      expected_rsp_beats.insert(expected_rsp_beats.size(), beat);
   endtask

   // ------------------------------------------------------------ parse model
   function automatic bit is_blank(input hbyte_type c);
      return c == brhp_pkg::CHAR_SPACE ||
             (c >= brhp_pkg::CHAR_TAB && c <= brhp_pkg::CHAR_CR);
   endfunction

   function automatic bit is_decimal(input hbyte_type c);
      return c >= brhp_pkg::CHAR_ZERO && c <= brhp_pkg::CHAR_NINE;
   endfunction

   // acc*10 + digit, pinned at the saturation value
   function automatic logic [47:0] shift_in_digit(input logic [47:0] acc, input hbyte_type c);
      logic [63:0] d;
      d = 64'(c - brhp_pkg::CHAR_ZERO);
      if (64'(acc) > (POS_LIMIT - d) / 64'd10) return POS_LIMIT[47:0];
      return 48'(64'(acc) * 64'd10 + d);
   endfunction

   task automatic open_model_range(input bit suffix, input parse_state_type nxt,
                                   input logic [47:0] first);
      cur_is_suffix = suffix;
      hdr_state     = nxt;
      cur_first     = first;
      cur_last      = '0;
      cur_have_last = 1'b0;
   endtask

   // Range end: clamp against the resource size, queue a beat if satisfiable.
   // A reversed first-last flags the header instead.
   task automatic close_model_range();
      logic [63:0]    cnt;
      logic [63:0]    hi;
      range_beat_type beat;
      bit             hit;
      beat = '0;
      hit  = 1'b0;
      if (cur_is_suffix) begin
         cnt = (cur_last < model_total_size) ? 64'(cur_last) : 64'(model_total_size);
         if (cnt != 0) begin
            beat.offset = brhp_pkg::OFFSET_W'(64'(model_total_size) - cnt);
            beat.length = brhp_pkg::LENGTH_W'(cnt);
            hit = 1'b1;
         end
      end else if (cur_have_last) begin
         if (cur_first > cur_last) begin
            hdr_malformed = 1'b1;
         end else if (cur_first < model_total_size) begin
            hi = (cur_last >= model_total_size) ? 64'(model_total_size) - 64'd1
                                                : 64'(cur_last);
            beat.offset = cur_first;
            beat.length = brhp_pkg::LENGTH_W'(hi - 64'(cur_first) + 64'd1);
            hit = 1'b1;
         end
      end else if (cur_first < model_total_size) begin
         // open end runs to the last byte of the resource
         beat.offset = cur_first;
         beat.length = brhp_pkg::LENGTH_W'(64'(model_total_size) - 64'(cur_first));
         hit = 1'b1;
      end
      if (hit) begin
         hdr_any_range = 1'b1;
         owe_beat(beat);
      end
   endtask

   // One accepted header byte: advance the grammar, queue the beats it owes.
   task automatic parse_header_byte(input hbyte_type c, input bit eoh);
      range_beat_type stat;
      int             idx;
      if (!hdr_malformed) begin
         case (hdr_state)
            ST_RANGE, ST_RANGE_WS: begin
               if (is_blank(c)) hdr_state = ST_RANGE_WS;
               else if (c == brhp_pkg::CHAR_DASH) open_model_range(1'b1, ST_SUFFIX, '0);
               else if (is_decimal(c))
                  open_model_range(1'b0, ST_FIRST, 48'(c - brhp_pkg::CHAR_ZERO));
               else hdr_malformed = 1'b1;
            end
            ST_FIRST: begin
               if (is_decimal(c)) cur_first = shift_in_digit(cur_first, c);
               else if (c == brhp_pkg::CHAR_DASH) hdr_state = ST_LAST;
               else hdr_malformed = 1'b1;
            end
            ST_LAST, ST_SUFFIX: begin
               if (is_decimal(c)) begin
                  cur_last      = shift_in_digit(cur_last, c);
                  cur_have_last = 1'b1;
               end else if (c == brhp_pkg::CHAR_COMMA || is_blank(c)) begin
                  close_model_range();
                  hdr_state = (c == brhp_pkg::CHAR_COMMA) ? ST_RANGE : ST_TRAIL;
               end else begin
                  hdr_malformed = 1'b1;
               end
            end
            ST_TRAIL: begin
               if (c == brhp_pkg::CHAR_COMMA) hdr_state = ST_RANGE;
               else if (!is_blank(c)) hdr_malformed = 1'b1;
            end
            default: begin
               idx = int'(hdr_state);
               if (c == PREFIX_TEXT[47 - 8 * idx -: 8])
                  hdr_state = parse_state_type'(idx + 1);
               else hdr_malformed = 1'b1;
            end
         endcase
      end
      if (eoh) begin
         if (!hdr_malformed) begin
            if (hdr_state == ST_LAST || hdr_state == ST_SUFFIX) close_model_range();
            else if (hdr_state != ST_RANGE && hdr_state != ST_TRAIL) hdr_malformed = 1'b1;
         end
         stat           = '0;
         stat.is_status = 1'b1;
         stat.last      = 1'b1;
         stat.status    = hdr_malformed ? brhp_pkg::STATUS_MALFORMED :
                          (hdr_any_range ? brhp_pkg::STATUS_OK : brhp_pkg::STATUS_NONE);
         owe_beat(stat);
         // next header starts clean; size register is kept
         hdr_state     = ST_B;
         cur_first     = '0;
         cur_last      = '0;
         cur_is_suffix = 1'b0;
         cur_have_last = 1'b0;
         hdr_any_range = 1'b0;
         hdr_malformed = 1'b0;
      end
   endtask

   // ------------------------------------------------------------ req_ driver
   // Entered at a clock edge; leaves req_valid high after the beat is taken so
   // a zero-gap follower can reuse it without a low pulse.
   task automatic send_header_byte(input hbyte_type c, input bit eoh);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_header_byte   <= c;
      req_end_of_header <= eoh;
      do @(posedge clock); while (req_stall !== 1'b0);
      parse_header_byte(c, eoh);
   endtask

   task automatic send_header();
      for (int i = 0; i < header_text.size(); i++)
         send_header_byte(header_text[i], i == header_text.size() - 1);
      header_bytes_sent += header_text.size();
      header_text.delete();
   endtask

   // Sender goes quiet until every owed beat is back, plus pipeline slack
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_rsp_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_total_size(input logic [brhp_pkg::SIZE_W-1:0] size);
      wait_results_drained();
      csr_write_enable <= 1'b1;
      csr_total_size   <= size;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_total_size = size;
   endtask

   // -------------------------------------------------------- text assembly
   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) add_text_byte(hbyte_type'(s[i]));
   endtask

   task automatic put_blank();
      if ($urandom_range(0, 5) == 0) add_text_byte(brhp_pkg::CHAR_SPACE);
      else add_text_byte(hbyte_type'(brhp_pkg::CHAR_TAB + $urandom_range(0, 4)));
   endtask

   // Decimal text; now and then leading zeros or a long digit run that can saturate
   task automatic put_number(input longint unsigned v);
      int digits;
      if ($urandom_range(0, 9) == 0) put_text("00");
      if ($urandom_range(0, 14) == 0) begin
         digits = $urandom_range(15, 22);
         repeat (digits)
            add_text_byte(hbyte_type'(brhp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
      end else begin
         put_text($sformatf("%0d", v));
      end
   endtask

   // Positions cluster around zero and around the end of the resource
   function automatic longint unsigned pick_position();
      longint unsigned t;
      case ($urandom_range(0, 5))
         0: t = $urandom_range(0, 20);
         1: begin
            t = longint'(model_total_size) + $urandom_range(0, 4);
            if (t >= 2) t -= 2;
         end
         2: t = (model_total_size == 0) ? 0 : {$urandom, $urandom} % model_total_size;
         3: t = {$urandom, $urandom} & SIZE_MASK;
         4: t = $urandom_range(0, 1000);
         default: t = $urandom_range(0, 100000);
      endcase
      return t;
   endfunction

   function automatic logic [brhp_pkg::SIZE_W-1:0] pick_total_size();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return brhp_pkg::SIZE_W'(1);
         2: return brhp_pkg::SIZE_W'($urandom_range(2, 100));
         3: return brhp_pkg::SIZE_W'($urandom_range(100, 100000));
         4: return brhp_pkg::SIZE_W'({$urandom, $urandom});
         default: return '1;
      endcase
   endfunction

   // Mostly well-formed range sets with random content; the rest is broken
   // prefixes and byte noise.
   task automatic build_random_header();
      int shape;
      int n_ranges;
      int cut;
      longint unsigned a;
      longint unsigned b;
      longint unsigned t;
      shape = $urandom_range(0, 99);
      if (shape < 85) begin
         put_text("bytes=");
         n_ranges = $urandom_range(0, 4);
         for (int i = 0; i < n_ranges; i++) begin
            if (i > 0) put_text(",");
            if ($urandom_range(0, 3) == 0) put_blank();
            a = pick_position();
            b = pick_position();
            case ($urandom_range(0, 2))
               0: begin
                  // mostly ordered, occasionally reversed
                  if (a > b && $urandom_range(0, 9) != 0) begin
                     t = a;
                     a = b;
                     b = t;
                  end
                  put_number(a);
                  put_text("-");
                  put_number(b);
               end
               1: begin
                  put_number(a);
                  put_text("-");
               end
               default: begin
                  put_text("-");
                  if ($urandom_range(0, 7) != 0) put_number(b);
               end
            endcase
            if ($urandom_range(0, 3) == 0) begin
               repeat ($urandom_range(1, 2)) put_blank();
            end
         end
         case ($urandom_range(0, 9))
            0: put_text(",");
            1: put_blank();
            default: ;
         endcase
         if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(0, header_text.size() - 1);
            if ($urandom_range(0, 1) == 0)
               header_text[cut] = hbyte_type'($urandom_range(0, 255));
            else while (header_text.size() > cut + 1) void'(header_text.pop_back());
         end
      end else if (shape < 93) begin
         put_text("bytes=");
         cut = $urandom_range(1, 6);
         while (header_text.size() > cut) void'(header_text.pop_back());
         repeat ($urandom_range(0, 3)) add_text_byte(hbyte_type'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8)) add_text_byte(hbyte_type'($urandom_range(0, 255)));
      end
   endtask

   // ------------------------------------------------------------ rsp_ check
   task automatic check_rsp_beat();
      range_beat_type exp;
      if (expected_rsp_beats.size() == 0) begin
         $error("result beat with no expectation pending");
         fail_count++;
      end else begin
         exp = expected_rsp_beats.pop_front();
         if (rsp_is_status !== exp.is_status) begin
            $error("is_status: expected %0d, got %0d", exp.is_status, rsp_is_status);
            fail_count++;
         end
         if (rsp_range_offset !== exp.offset) begin
            $error("range_offset: expected %0d, got %0d", exp.offset, rsp_range_offset);
            fail_count++;
         end
         if (rsp_range_length !== exp.length) begin
            $error("range_length: expected %0d, got %0d", exp.length, rsp_range_length);
            fail_count++;
         end
         if (rsp_status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, rsp_status);
            fail_count++;
         end
         if (rsp_last_result !== exp.last) begin
            $error("last_result: expected %0d, got %0d", exp.last, rsp_last_result);
            fail_count++;
         end
      end
   endtask

   // Receiver: random stall before each beat, or the one-shot long hold-off
   initial begin : rsp_side
      int hold;
      wait (reset === 1'b0);
      forever begin
         if (rsp_hold_cycles > 0) begin
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            hold = rsp_burst ? 0 : $urandom_range(0, 9);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         check_rsp_beat();
      end
   end

   // ------------------------------------------------------------------ tests
   // Grammar corners at a size of 1000: every range form, empty lists,
   // whitespace, saturation, clamping, drops and each malformed shape.
   task automatic test_directed_headers();
      write_total_size(brhp_pkg::SIZE_W'(1000));
      put_text("bytes=0-0,5-");                 send_header();
      put_text("bytes=");                       send_header();  // empty list
      put_text("bytes=1-2,");                   send_header();  // trailing comma
      put_text("bytes=-");                      send_header();  // zero suffix
      put_text("bytes=-5000");                  send_header();  // suffix clamp
      put_text("bytes=9-3");                    send_header();  // reversed
      put_text("bytes=2000-,0-9");              send_header();  // drop, keep going
      put_text("bytes=");
      put_blank();
      put_text("1-2");
      add_text_byte(brhp_pkg::CHAR_SPACE);
      add_text_byte(brhp_pkg::CHAR_CR);
      put_text(",");
      add_text_byte(8'h0B);
      put_text("-5");
      add_text_byte(brhp_pkg::CHAR_TAB);        send_header();
      put_text("bytes= ");                      send_header();  // blank, no range
      put_text("bytes=1-2, ");                  send_header();  // blank after comma
      put_text("bytes=0-1,,2-3");               send_header();  // double comma
      put_text("bytes=5");                      send_header();  // no dash
      put_text("byt");                          send_header();  // short prefix
      put_text("Bytes=0-1");                    send_header();  // case matters
      put_text("bytes=99999999999999999999-");  send_header();  // saturated start
      put_text("bytes=0-99999999999999999999"); send_header();  // saturated end
      put_text("bytes=1-2");
      add_text_byte(8'hFF);                     send_header();  // stray high byte
      add_text_byte(8'h00);                     send_header();  // lone NUL
      put_text("bytes=1-2 x");                  send_header();  // junk after range
   endtask

   // Empty resource, one byte, the largest size and a random one
   task automatic test_size_extremes();
      logic [brhp_pkg::SIZE_W-1:0] sizes[4];
      sizes[0] = '0;
      sizes[1] = brhp_pkg::SIZE_W'(1);
      sizes[2] = '1;
      sizes[3] = brhp_pkg::SIZE_W'({$urandom, $urandom});
      foreach (sizes[i]) begin
         write_total_size(sizes[i]);
         put_text("bytes=0-,-99999999999999999999,0-0"); send_header();
         put_text("bytes=-1,5-");                        send_header();
         repeat (2) begin
            build_random_header();
            send_header();
         end
      end
   endtask

   // Receiver holds off for a long stretch while bytes keep coming back to
   // back: the result queue fills and req_stall must throttle the input.
   task automatic test_result_backlog();
      write_total_size(brhp_pkg::SIZE_W'(1000));
      rsp_hold_cycles = 200;
      send_burst      = 1'b1;
      repeat (4) begin
         put_text("bytes=0-0,1-1,2-2,3-3,4-4,5-5"); send_header();
      end
      send_burst = 1'b0;
   endtask

   // Sender stops after each header until every result is back
   task automatic test_drain_pause();
      repeat (3) begin
         build_random_header();
         send_header();
         wait_results_drained();
      end
   endtask

   // Random headers in phases, each phase under its own resource size
   task automatic test_random_headers();
      int unsigned start_bytes;
      int unsigned next_size_at;
      start_bytes  = header_bytes_sent;
      next_size_at = 0;
      while (header_bytes_sent - start_bytes < RANDOM_BYTES) begin
         if (header_bytes_sent - start_bytes >= next_size_at) begin
            write_total_size(pick_total_size());
            next_size_at += BYTES_PER_SIZE;
         end
         // stretches with no idling on either side
         send_burst = ($urandom_range(0, 4) == 0);
         rsp_burst  = ($urandom_range(0, 4) == 0);
         build_random_header();
         send_header();
      end
      send_burst = 1'b0;
      rsp_burst  = 1'b0;
   endtask

   // ------------------------------------------------------------- run order
   initial begin : test_sequence
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_headers();
      test_size_extremes();
      test_result_backlog();
      test_drain_pause();
      test_random_headers();
      wait_results_drained();
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // Hang guard; far above the slowest legal run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

endmodule
